// ===== src/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// Median of two sorted lists: shared package
// Widths, list depth, sentinel bounds, command and state codes, and the
// request bundle that drives one list memory.
// ----------------------------------------------------------------------------
package msl_pkg;

	localparam int LIST_DEPTH = 1024;
	localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	// Search indexes are signed and must hold -1 and twice the depth.
	localparam int IDX_W      = CNT_W + 2;
	localparam int DATA_W     = 32;
	localparam int RES_W      = DATA_W + 1;
	localparam int EXT_W      = DATA_W + 2;

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic signed [IDX_W-1:0]  idx_t;
	typedef logic signed [EXT_W-1:0]  ext_t;
	typedef logic signed [RES_W-1:0]  res_t;

	localparam count_t FULL_CNT   = count_t'(LIST_DEPTH);
	// Bounds that lie below and above every 32-bit value.
	localparam ext_t   LOW_BOUND  = ext_t'({2'b11, {DATA_W{1'b0}}});
	localparam ext_t   HIGH_BOUND = ext_t'({2'b01, {DATA_W{1'b0}}});

	typedef enum logic [1:0] {
		MODE_PUSH_FIRST  = 2'd0,
		MODE_PUSH_SECOND = 2'd1,
		MODE_COMPUTE     = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDR,
		S_CMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		elem_t wdata;
		addr_t raddr0;
		addr_t raddr1;
	} ram_req_t;

endpackage

// ===== src/msl_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Carries one push or compute item from the source to the block.
// ----------------------------------------------------------------------------
interface msl_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

// ===== src/msl_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries one median item from the block to the receiver.
// ----------------------------------------------------------------------------
interface msl_res_if;
	logic               valid;
	logic               ready;
	logic signed [32:0] median_doubled;
	logic               found;
	logic               overflowed;

	modport source (output valid, output median_doubled, output found,
		output overflowed, input ready);
	modport sink (input valid, input median_doubled, input found,
		input overflowed, output ready);
endinterface

// ===== src/msl_list_ram.sv =====
// ----------------------------------------------------------------------------
// List memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module msl_list_ram (
	input  logic              clk,
	input  msl_pkg::ram_req_t req,
	output msl_pkg::elem_t    rdata0,
	output msl_pkg::elem_t    rdata1
);
	import msl_pkg::*;

	elem_t mem [LIST_DEPTH];
	elem_t rd0_q;
	elem_t rd1_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd0_q <= mem[req.raddr0];
		rd1_q <= mem[req.raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

// ===== src/median_of_two_sorted_lists.sv =====
// ----------------------------------------------------------------------------
// Median of two sorted lists
// Stores two ascending lists and binary-searches their median on request.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on cmd. Mode push-first or push-second appends value to that
// list; a push to a full list is dropped and sets a sticky overflow flag.
// Mode compute starts the search and empties both lists.
// Each compute item yields one item on res: twice the median, a found bit,
// and the overflow flag gathered since the previous compute.
// Pushes are taken back to back, one per cycle, while no search runs. A compute
// item holds cmd ready low while the search runs. Each search step passes
// through S_ADDR, where both list memories are read, and S_CMP, where the
// registered read data meet the partition compare; there are at most
// log2(shorter count + 1) + 1 steps. A found partition goes from S_CMP to
// S_FIN; a search that ends without one goes there from S_ADDR. Both lists
// empty go straight from S_IDLE to S_FIN.
// A stalled receiver holds the result in the output register; pushes are
// still taken, and a further compute waits at its end for the register.
// Reset clears the counts, the overflow flag and the output; the list
// memories are not cleared, as only entries below the counts are read.
// ----------------------------------------------------------------------------
module median_of_two_sorted_lists (
	input logic         clk,
	input logic         arst_n,
	msl_cmd_if.sink     cmd,
	msl_res_if.source   res
);
	import msl_pkg::*;

	state_t   state_q, state_d;
	count_t   first_count_q, second_count_q;
	logic     ovf_flag_q;

	logic     swap_q, odd_q, ovf_q, hit_q;
	idx_t     x_q, y_q, half_q, lo_q, hi_q, px_q, py_q;
	ext_t     left_q, right_q;

	logic     res_valid_q, res_found_q, res_ovf_q;
	res_t     res_md_q;

	ram_req_t first_req, second_req;
	elem_t    first_rd0, first_rd1, second_rd0, second_rd1;

	logic     cmd_acc, push_first, push_second, do_compute;
	logic     out_free;
	idx_t     x_c, y_c, total_c, px_c, py_c, pxm_c, pym_c;
	logic     step_ok;
	elem_t    sa_d0, sa_d1, lb_d0, lb_d1;
	ext_t     lx, rx, ly, ry, sum_c;
	logic     fit_l, fit_r;

	assign cmd.ready   = (state_q == S_IDLE);
	assign cmd_acc     = cmd.valid && cmd.ready;
	assign push_first  = cmd_acc && (cmd.mode == MODE_PUSH_FIRST);
	assign push_second = cmd_acc && (cmd.mode == MODE_PUSH_SECOND);
	assign do_compute  = cmd_acc && (cmd.mode == MODE_COMPUTE);
	assign out_free    = !res_valid_q || res.ready;

	// The shorter list is searched; ties keep the first list as the short one.
	assign x_c     = (first_count_q > second_count_q) ? idx_t'(second_count_q)
		: idx_t'(first_count_q);
	assign y_c     = (first_count_q > second_count_q) ? idx_t'(first_count_q)
		: idx_t'(second_count_q);
	assign total_c = x_c + y_c;

	assign px_c    = (lo_q + hi_q) >>> 1;
	assign py_c    = half_q - px_c;
	assign pxm_c   = px_c - idx_t'(1);
	assign pym_c   = py_c - idx_t'(1);
	assign step_ok = (lo_q <= hi_q) && (py_c >= idx_t'(0)) && (py_c <= y_q);

	// Memory requests: writes on pushes, reads of both partition edges.
	always_comb begin
		first_req.we      = push_first && (first_count_q != FULL_CNT);
		first_req.waddr   = first_count_q[ADDR_W-1:0];
		first_req.wdata   = cmd.value;
		first_req.raddr0  = swap_q ? pym_c[ADDR_W-1:0] : pxm_c[ADDR_W-1:0];
		first_req.raddr1  = swap_q ? py_c[ADDR_W-1:0] : px_c[ADDR_W-1:0];
		second_req.we     = push_second && (second_count_q != FULL_CNT);
		second_req.waddr  = second_count_q[ADDR_W-1:0];
		second_req.wdata  = cmd.value;
		second_req.raddr0 = swap_q ? pxm_c[ADDR_W-1:0] : pym_c[ADDR_W-1:0];
		second_req.raddr1 = swap_q ? px_c[ADDR_W-1:0] : py_c[ADDR_W-1:0];
	end

	msl_list_ram u_first_ram (
		.clk    (clk),
		.req    (first_req),
		.rdata0 (first_rd0),
		.rdata1 (first_rd1)
	);

	msl_list_ram u_second_ram (
		.clk    (clk),
		.req    (second_req),
		.rdata0 (second_rd0),
		.rdata1 (second_rd1)
	);

	// Partition edges, with the outer bounds at the list ends.
	assign sa_d0 = swap_q ? second_rd0 : first_rd0;
	assign sa_d1 = swap_q ? second_rd1 : first_rd1;
	assign lb_d0 = swap_q ? first_rd0 : second_rd0;
	assign lb_d1 = swap_q ? first_rd1 : second_rd1;
	assign lx    = (px_q == idx_t'(0)) ? LOW_BOUND : ext_t'(sa_d0);
	assign rx    = (px_q == x_q) ? HIGH_BOUND : ext_t'(sa_d1);
	assign ly    = (py_q == idx_t'(0)) ? LOW_BOUND : ext_t'(lb_d0);
	assign ry    = (py_q == y_q) ? HIGH_BOUND : ext_t'(lb_d1);
	assign fit_l = (lx <= ry);
	assign fit_r = (ly <= rx);

	assign sum_c = odd_q ? (left_q <<< 1) : (left_q + right_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (do_compute) begin
					state_d = (total_c == idx_t'(0)) ? S_FIN : S_ADDR;
				end
			end
			S_ADDR: begin
				state_d = step_ok ? S_CMP : S_FIN;
			end
			S_CMP: begin
				state_d = (fit_l && fit_r) ? S_FIN : S_ADDR;
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// List counts and the sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			ovf_flag_q     <= 1'b0;
		end else if (do_compute) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			ovf_flag_q     <= 1'b0;
		end else begin
			if (push_first) begin
				if (first_req.we) begin
					first_count_q <= first_count_q + count_t'(1);
				end else begin
					ovf_flag_q <= 1'b1;
				end
			end
			if (push_second) begin
				if (second_req.we) begin
					second_count_q <= second_count_q + count_t'(1);
				end else begin
					ovf_flag_q <= 1'b1;
				end
			end
		end
	end

	// Search datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (do_compute) begin
					swap_q <= (first_count_q > second_count_q);
					x_q    <= x_c;
					y_q    <= y_c;
					half_q <= (total_c + idx_t'(1)) >>> 1;
					odd_q  <= total_c[0];
					lo_q   <= '0;
					hi_q   <= x_c;
					ovf_q  <= ovf_flag_q;
					hit_q  <= 1'b0;
				end
			end
			S_ADDR: begin
				px_q <= px_c;
				py_q <= py_c;
			end
			S_CMP: begin
				if (fit_l && fit_r) begin
					hit_q   <= 1'b1;
					left_q  <= (lx > ly) ? lx : ly;
					right_q <= (rx < ry) ? rx : ry;
				end else if (!fit_l) begin
					hi_q <= px_q - idx_t'(1);
				end else begin
					lo_q <= px_q + idx_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			res_md_q    <= hit_q ? sum_c[RES_W-1:0] : '0;
			res_found_q <= hit_q;
			res_ovf_q   <= ovf_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.median_doubled = res_md_q;
	assign res.found          = res_found_q;
	assign res.overflowed     = res_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(first_count_q <= FULL_CNT) && (second_count_q <= FULL_CNT))
		else $error("list count beyond depth");

	a_clear_on_compute: assert property (@(posedge clk) disable iff (!arst_n)
		do_compute |=> (first_count_q == '0) && (second_count_q == '0) && !ovf_flag_q)
		else $error("lists not cleared after compute");

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !first_req.we && !second_req.we)
		else $error("list written during search");

	a_partition_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (px_q >= idx_t'(0)) && (px_q <= x_q)
			&& (py_q >= idx_t'(0)) && (py_q <= y_q))
		else $error("partition index out of range");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median of two sorted lists: testbench
// Pushes mostly ascending lists into both stores and asks for their median. A model
// of the list stores and the partition search, kept inside this module,
// predicts each median item, which is checked field by field as it leaves
// the block. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import msl_pkg::*;

	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	localparam elem_t      ELEM_MIN     = elem_t'(32'h8000_0000);
	localparam elem_t      ELEM_MAX     = elem_t'(32'h7FFF_FFFF);
	localparam longint     BELOW_ALL    = -(longint'(1) << 32);
	localparam longint     ABOVE_ALL    = longint'(1) << 32;
	localparam int         QUIET_LIMIT  = 2000;
	localparam int         RANDOM_ITEMS = 450;
	localparam int         CALM_ITEMS   = 80;

	typedef enum int {
		SPREAD_WIDE,
		SPREAD_NARROW,
		SPREAD_EDGES
	} spread_t;

	typedef struct {
		res_t median;
		bit   found;
		bit   overflowed;
	} median_t;

	logic clk = 1'b0;
	logic arst_n;

	msl_cmd_if cmd_ch();
	msl_res_if res_ch();

	median_of_two_sorted_lists dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	// Model of the block.
	elem_t   first_store[LIST_DEPTH];
	elem_t   second_store[LIST_DEPTH];
	int      first_cnt;
	int      second_cnt;
	bit      push_dropped;
	median_t pending_medians[$];

	elem_t scratch_vals[$];
	elem_t first_vals[$];
	elem_t second_vals[$];

	int errors = 0;
	int quiet_cycles = 0;
	int items_sent;
	bit calm;
	int stall_left = 0;

	function automatic longint list_at(bit from_second, int idx);
		return from_second ? longint'(second_store[idx]) : longint'(first_store[idx]);
	endfunction

	// Binary search for a partition of the shorter list against the longer.
	function automatic median_t predict_median();
		median_t m;
		bit      short_second;
		bit      done;
		int      x, y, lo, hi, half, px, py;
		longint  lx, rx, ly, ry, left;
		m.median     = '0;
		m.found      = 1'b0;
		m.overflowed = push_dropped;
		short_second = first_cnt > second_cnt;
		x = short_second ? second_cnt : first_cnt;
		y = short_second ? first_cnt : second_cnt;
		half = (x + y + 1) / 2;
		lo = 0;
		hi = x;
		done = (x + y == 0);
		while (!done && lo <= hi) begin
			px = (lo + hi) / 2;
			py = half - px;
			if (py < 0 || py > y) begin
				done = 1'b1;
			end else begin
				lx = (px == 0) ? BELOW_ALL : list_at(short_second, px - 1);
				rx = (px == x) ? ABOVE_ALL : list_at(short_second, px);
				ly = (py == 0) ? BELOW_ALL : list_at(!short_second, py - 1);
				ry = (py == y) ? ABOVE_ALL : list_at(!short_second, py);
				if (lx <= ry && ly <= rx) begin
					left = (lx > ly) ? lx : ly;
					if ((x + y) % 2 == 0)
						m.median = res_t'(left + ((rx < ry) ? rx : ry));
					else
						m.median = res_t'(2 * left);
					m.found = 1'b1;
					done = 1'b1;
				end else if (lx > ry) begin
					hi = px - 1;
				end else begin
					lo = px + 1;
				end
			end
		end
		return m;
	endfunction

	function automatic void apply_item(logic [1:0] mode, elem_t value);
		case (mode)
			MODE_PUSH_FIRST: begin
				if (first_cnt < LIST_DEPTH) begin
					first_store[first_cnt] = value;
					first_cnt++;
				end else begin
					push_dropped = 1'b1;
				end
			end
			MODE_PUSH_SECOND: begin
				if (second_cnt < LIST_DEPTH) begin
					second_store[second_cnt] = value;
					second_cnt++;
				end else begin
					push_dropped = 1'b1;
				end
			end
			MODE_COMPUTE: begin
				pending_medians.push_back(predict_median());
				first_cnt = 0;
				second_cnt = 0;
				push_dropped = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	// Presents one item and returns at the edge that accepts it. The valid
	// stays high so that the next item can follow without a gap.
	task automatic send_item(logic [1:0] mode, elem_t value);
		if (!calm && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode  <= mode;
		cmd_ch.value <= value;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		apply_item(mode, value);
		if (mode != MODE_UNUSED)
			items_sent++;
	endtask

	// Fills scratch_vals with n values in ascending order, or scrambled by
	// random swaps when asked.
	task automatic make_values(int n, spread_t spread, bit scramble);
		elem_t v, base, tmp;
		int    i, j, k;
		scratch_vals.delete();
		base = elem_t'($urandom);
		for (i = 0; i < n; i++) begin
			case (spread)
				SPREAD_WIDE:   v = elem_t'($urandom);
				SPREAD_NARROW: v = base + elem_t'($urandom_range(0, 7));
				default: begin
					case ($urandom_range(0, 3))
						0: v = ELEM_MIN;
						1: v = ELEM_MAX;
						2: v = ($urandom_range(0, 1) == 0) ? ELEM_MIN + 1 : ELEM_MAX - 1;
						default: v = elem_t'($urandom_range(0, 7)) - 4;
					endcase
				end
			endcase
			j = 0;
			while (j < scratch_vals.size() && scratch_vals[j] <= v) j++;
			scratch_vals.insert(j, v);
		end
		if (scramble && n > 1) begin
			for (k = 0; k < n; k++) begin
				i = $urandom_range(0, n - 1);
				j = $urandom_range(0, n - 1);
				tmp = scratch_vals[i];
				scratch_vals[i] = scratch_vals[j];
				scratch_vals[j] = tmp;
			end
		end
	endtask

	// Interleaves first_vals and second_vals at random, with the odd unused
	// item mixed in, then asks for the median.
	task automatic push_lists_and_compute();
		while (first_vals.size() + second_vals.size() > 0) begin
			if ($urandom_range(0, 11) == 0)
				send_item(MODE_UNUSED, elem_t'($urandom));
			if (second_vals.size() == 0 || (first_vals.size() > 0 && $urandom_range(0, 1) == 0))
				send_item(MODE_PUSH_FIRST, first_vals.pop_front());
			else
				send_item(MODE_PUSH_SECOND, second_vals.pop_front());
		end
		send_item(MODE_COMPUTE, elem_t'($urandom));
	endtask

	task automatic test_directed();
		send_item(MODE_COMPUTE, ELEM_MAX);
		send_item(MODE_PUSH_FIRST, ELEM_MIN);
		send_item(MODE_COMPUTE, '0);
		send_item(MODE_PUSH_SECOND, ELEM_MAX);
		send_item(MODE_COMPUTE, ELEM_MIN);
		send_item(MODE_PUSH_FIRST, ELEM_MAX);
		send_item(MODE_PUSH_SECOND, ELEM_MAX);
		send_item(MODE_COMPUTE, '0);
		send_item(MODE_PUSH_FIRST, ELEM_MIN);
		send_item(MODE_PUSH_SECOND, ELEM_MIN);
		send_item(MODE_COMPUTE, '1);
		// An unused mode between the pushes must leave both lists alone.
		send_item(MODE_PUSH_FIRST, -5);
		send_item(MODE_UNUSED, 100);
		send_item(MODE_PUSH_SECOND, 8);
		send_item(MODE_COMPUTE, '0);
		// Lists that are not in order.
		send_item(MODE_PUSH_FIRST, 10);
		send_item(MODE_PUSH_FIRST, 2);
		send_item(MODE_PUSH_SECOND, 7);
		send_item(MODE_PUSH_SECOND, 1);
		send_item(MODE_PUSH_SECOND, 0);
		send_item(MODE_COMPUTE, '0);
		send_item(MODE_PUSH_FIRST, 1);
		send_item(MODE_PUSH_FIRST, 2);
		send_item(MODE_PUSH_SECOND, 3);
		send_item(MODE_PUSH_SECOND, 4);
		send_item(MODE_COMPUTE, '0);
	endtask

	// Full lists: pushes past the depth are dropped and flagged, and the
	// flag is gone again at the next compute.
	task automatic test_full_lists();
		make_values(LIST_DEPTH + 1, SPREAD_WIDE, 1'b0);
		first_vals = scratch_vals;
		second_vals.delete();
		push_lists_and_compute();
		make_values(LIST_DEPTH, SPREAD_WIDE, 1'b0);
		first_vals = scratch_vals;
		make_values(LIST_DEPTH + 2, SPREAD_WIDE, 1'b0);
		second_vals = scratch_vals;
		push_lists_and_compute();
		send_item(MODE_PUSH_SECOND, 0);
		send_item(MODE_COMPUTE, '0);
	endtask

	task automatic test_random();
		int goal, n1, n2;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			calm = (items_sent > goal - CALM_ITEMS);
			n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			make_values(n1, spread_t'($urandom_range(0, 2)), $urandom_range(0, 7) == 0);
			first_vals = scratch_vals;
			make_values(n2, spread_t'($urandom_range(0, 2)), $urandom_range(0, 7) == 0);
			second_vals = scratch_vals;
			push_lists_and_compute();
		end
	endtask

	task automatic flag_mismatch(string field, longint want, longint got);
		errors++;
		$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin : median_check
		median_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_medians.size() == 0) begin
				errors++;
				$display("%0t: unexpected median item: median_doubled %0d found %0b overflowed %0b",
					$time, res_ch.median_doubled, res_ch.found, res_ch.overflowed);
			end else begin
				want = pending_medians.pop_front();
				if (res_ch.median_doubled !== want.median)
					flag_mismatch("median_doubled", longint'(want.median),
						longint'(res_ch.median_doubled));
				if (res_ch.found !== want.found)
					flag_mismatch("found", want.found, res_ch.found);
				if (res_ch.overflowed !== want.overflowed)
					flag_mismatch("overflowed", want.overflowed, res_ch.overflowed);
			end
		end
	end

	// The receiver stalls in bursts.
	always @(posedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 14);
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode  = MODE_PUSH_FIRST;
		cmd_ch.value = '0;
		items_sent   = 0;
		calm         = 1'b0;
		first_cnt    = 0;
		second_cnt   = 0;
		push_dropped = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_lists();
		test_random();
		cmd_ch.valid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
